// ===== rtl/core/thbt_pkg.sv =====
package thbt_pkg;

  // Batch and converter sizing.
  localparam int BATCH_SIZE = 4;
  localparam int ADC_BITS   = 12;
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = ADC_BITS + $clog2(BATCH_SIZE + 1);
  localparam int CNT_W      = $clog2(BATCH_SIZE + 1);

  // Register map.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_BETA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF     = 3'd4;

  localparam int BETA_W   = 14;
  localparam int OHMS_W   = 20;
  localparam int SUPPLY_W = 14;
  localparam int REF_W    = 13;

  // Datapath widths: divider voltage product and its complement.
  localparam int NUM_W = ADC_BITS + REF_W;
  localparam int DEN_W = ADC_BITS + SUPPLY_W + 1;

  // Output format.
  localparam int TEMP_W = 17;
  localparam int ZERO_K_CENTI = 27315;
  localparam int TEMP_MAX     = 60000;

  // Fixed point constants.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [63:0] INV_T0_Q40 =
    ((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815;
  localparam logic [47:0] CENTI_ONE_Q40 = 48'd100 << 40;

  // Divider and queue sizing.
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [BETA_W-1:0]   beta;
    logic [OHMS_W-1:0]   nominal;
    logic [OHMS_W-1:0]   divider;
    logic [SUPPLY_W-1:0] supply;
    logic [REF_W-1:0]    vref;
  } cfg_t;

  // One batch average moving through the queue.
  typedef struct packed {
    logic                valid;
    logic [ADC_BITS-1:0] avg;
  } avg_word_t;

endpackage

// ===== rtl/core/thbt_fifo.sv =====
module thbt_fifo
  import thbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  avg_word_t push,
  output logic      full,
  input  logic      pop,
  output avg_word_t head
);

  logic [ADC_BITS-1:0]   mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r;
  logic                  do_push, do_pop;

  assign full     = (count_r == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign do_push  = push.valid && !full;
  assign do_pop   = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.avg   = mem_r[rd_ptr_r];

  // Storage and pointers.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.avg;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (FIFO_PTR_W + 1)'(do_push) - (FIFO_PTR_W + 1)'(do_pop);
    end
  end

endmodule

// ===== rtl/core/thbt_front.sv =====
module thbt_front
  import thbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_abort,
  input  logic                queue_full,
  output avg_word_t           push
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_add;
  logic             accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign sum_add  = sum_r + SUM_W'(in_sample[ADC_BITS-1:0]);

  // Batch accumulation; a full batch pushes its truncated average, an abort clears it.
  always_comb begin
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    push.valid = 1'b0;
    push.avg   = ADC_BITS'(sum_add / BATCH_SIZE);
    if (accept) begin
      if (in_abort) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else if (cnt_r == CNT_W'(BATCH_SIZE - 1)) begin
        sum_nxt    = '0;
        cnt_nxt    = '0;
        push.valid = 1'b1;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/thbt_back.sv =====
module thbt_back
  import thbt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  avg_word_t                head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] out_temp_centi,
  output logic                     out_fault
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_NORM, ST_SQR, ST_LN, ST_DIV1, ST_INV, ST_DIV2, ST_FIN, ST_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ADC_BITS-1:0]        avg_r, avg_nxt;
  logic [NUM_W-1:0]           num_r, num_nxt;
  logic [DEN_W-2:0]           den_r, den_nxt;
  logic [1:0]                 op_r, op_nxt;
  logic [31:0]                m_r, m_nxt;
  logic [4:0]                 k_r, k_nxt;
  logic [23:0]                frac_r, frac_nxt;
  logic [DIV_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic signed [31:0]         l2_r, l2_nxt;
  logic                       neg_r, neg_nxt;
  logic [DIV_W-1:0]           quo_r, quo_nxt;
  logic [DIV_W:0]             rem_r, rem_nxt;
  logic [DIV_W-1:0]           dsr_r, dsr_nxt;
  logic signed [TEMP_W-1:0]   res_temp_r, res_temp_nxt;
  logic                       res_fault_r, res_fault_nxt;
  logic signed [TEMP_W-1:0]   out_temp_r, out_temp_nxt;
  logic                       out_fault_r, out_fault_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [NUM_W-1:0]           num_prod;
  logic signed [DEN_W-1:0]    den_s;
  logic                       bad;
  logic [63:0]                sq_prod;
  logic [32:0]                sq;
  logic [31:0]                m_step;
  logic [23:0]                frac_step;
  logic signed [31:0]         log_val;
  logic [30:0]                l2_mag;
  logic [62:0]                ln_prod;
  logic [DIV_W:0]             rem_sh;
  logic                       rem_ge;
  logic signed [DIV_W+1:0]    term_s, inv_s;
  logic                       q_adj;
  logic signed [TEMP_W:0]     q_s;

  // Operand of each logarithm: divider, num, nominal, den.
  function automatic logic [31:0] operand(input logic [1:0] idx, input cfg_t c,
                                          input logic [NUM_W-1:0] n,
                                          input logic [DEN_W-2:0] d);
    logic [31:0] v;
    case (idx)
      2'd0:    v = 32'(c.divider);
      2'd1:    v = 32'(n);
      2'd2:    v = 32'(c.nominal);
      default: v = 32'(d);
    endcase
    return v;
  endfunction

  assign pop            = (state_r == ST_IDLE) && head.valid;
  assign out_valid      = out_valid_r;
  assign out_temp_centi = out_temp_r;
  assign out_fault      = out_fault_r;

  // Datapath pieces shared by the sequencer.
  always_comb begin
    num_prod  = NUM_W'(avg_r) * NUM_W'(cfg.vref);
    den_s     = $signed({1'b0, cfg.supply, {ADC_BITS{1'b0}}}) - $signed({2'b0, num_prod});
    bad       = (num_prod == '0) || (den_s <= 0) || (cfg.beta == '0) ||
                (cfg.nominal == '0) || (cfg.divider == '0);
    sq_prod   = 64'(m_r) * 64'(m_r);
    sq        = sq_prod[63:31];
    m_step    = sq[32] ? sq[32:1] : sq[31:0];
    frac_step = {frac_r[22:0], sq[32]};
    log_val   = $signed({3'b0, k_r, frac_step});
    l2_mag    = l2_r[31] ? 31'(-l2_r) : l2_r[30:0];
    ln_prod   = 63'(l2_mag) * 63'(LN2_Q32);
    rem_sh    = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    rem_ge    = (rem_sh >= {1'b0, dsr_r});
    term_s    = $signed({2'b0, quo_r});
    inv_s     = $signed((DIV_W + 2)'(INV_T0_Q40)) + (neg_r ? -term_s : term_s);
    q_adj     = (quo_r < DIV_W'(ZERO_K_CENTI)) && (rem_r != '0);
    q_s       = $signed({1'b0, quo_r[TEMP_W-1:0]}) - (TEMP_W + 1)'(ZERO_K_CENTI)
                + (TEMP_W + 1)'(q_adj);
  end

  // Sequencer: setup, four logarithms, ln scaling, two divisions, finish.
  always_comb begin
    state_nxt     = state_r;
    avg_nxt       = avg_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    op_nxt        = op_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    frac_nxt      = frac_r;
    cnt_nxt       = cnt_r;
    l2_nxt        = l2_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    res_temp_nxt  = res_temp_r;
    res_fault_nxt = res_fault_r;
    out_temp_nxt  = out_temp_r;
    out_fault_nxt = out_fault_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          avg_nxt   = head.avg;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        num_nxt = num_prod;
        den_nxt = den_s[DEN_W-2:0];
        if (bad) begin
          res_temp_nxt  = -TEMP_W'(ZERO_K_CENTI);
          res_fault_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          op_nxt    = 2'd0;
          l2_nxt    = '0;
          m_nxt     = 32'(cfg.divider);
          k_nxt     = 5'd31;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (m_r[31]) begin
          cnt_nxt   = '0;
          frac_nxt  = '0;
          state_nxt = ST_SQR;
        end else begin
          m_nxt = {m_r[30:0], 1'b0};
          k_nxt = k_r - 1'b1;
        end
      end
      ST_SQR: begin
        m_nxt    = m_step;
        frac_nxt = frac_step;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(23)) begin
          l2_nxt = op_r[1] ? l2_r - log_val : l2_r + log_val;
          if (op_r == 2'd3) begin
            state_nxt = ST_LN;
          end else begin
            op_nxt    = op_r + 1'b1;
            m_nxt     = operand(op_r + 1'b1, cfg, num_r, den_r);
            k_nxt     = 5'd31;
            state_nxt = ST_NORM;
          end
        end
      end
      ST_LN: begin
        neg_nxt   = l2_r[31];
        quo_nxt   = {1'b0, ln_prod[62:32], 16'b0};
        rem_nxt   = '0;
        dsr_nxt   = DIV_W'(cfg.beta);
        cnt_nxt   = '0;
        state_nxt = ST_DIV1;
      end
      ST_DIV1, ST_DIV2: begin
        rem_nxt = rem_ge ? rem_sh - {1'b0, dsr_r} : rem_sh;
        quo_nxt = {quo_r[DIV_W-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          state_nxt = (state_r == ST_DIV1) ? ST_INV : ST_FIN;
        end
      end
      ST_INV: begin
        if (inv_s <= 0) begin
          res_temp_nxt  = TEMP_W'(TEMP_MAX);
          res_fault_nxt = 1'b0;
          state_nxt     = ST_DONE;
        end else begin
          quo_nxt   = CENTI_ONE_Q40;
          rem_nxt   = '0;
          dsr_nxt   = inv_s[DIV_W-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_DIV2;
        end
      end
      ST_FIN: begin
        res_fault_nxt = 1'b0;
        if (quo_r > DIV_W'(TEMP_MAX + ZERO_K_CENTI)) begin
          res_temp_nxt = TEMP_W'(TEMP_MAX);
        end else begin
          res_temp_nxt = q_s[TEMP_W-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_temp_nxt  = res_temp_r;
          out_fault_nxt = res_fault_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    avg_r       <= avg_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    op_r        <= op_nxt;
    m_r         <= m_nxt;
    k_r         <= k_nxt;
    frac_r      <= frac_nxt;
    cnt_r       <= cnt_nxt;
    l2_r        <= l2_nxt;
    neg_r       <= neg_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dsr_r       <= dsr_nxt;
    res_temp_r  <= res_temp_nxt;
    res_fault_r <= res_fault_nxt;
    out_temp_r  <= out_temp_nxt;
    out_fault_r <= out_fault_nxt;
  end

endmodule

// ===== rtl/core/thermistor_beta_temperature_core.sv =====
// NTC thermistor temperature from batches of ADC samples.
// Input channel: in_valid/in_ready carry one word, a 12-bit sample and an
// abort flag. Every fourth sample closes a batch; abort drops the partial
// batch and yields no result. A word is taken whenever the
// two-entry average queue has room.
// Output channel: out_valid/out_ready carry one word per batch, the
// temperature in hundredths of a degree Celsius and a fault flag.
// Four logarithms by normalize-and-square and two 48-step bit-serial
// divisions lie between the closing sample and the result. A fault word
// goes from setup straight to the output and skips all of that.
// The sequencer works on one batch average at a time and takes the next
// from the queue only after the current result has moved to the output register.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write only
// while the block is idle. Indexes above four are ignored.
// Reset (rst_n low, synchronous) restores the default registers and clears
// the batch, the queue and the output. When the receiver stalls, the result
// holds in the output register; the next result waits in the sequencer and
// later averages wait in the queue, after which in_ready drops.
module thermistor_beta_temperature_core
  import thbt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_W-1:0]      in_sample,
  input  logic                     in_abort,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] out_temp_centi,
  output logic                     out_fault,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  cfg_t      cfg_r;
  avg_word_t push, head;
  logic      queue_full, pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beta    <= BETA_W'(3988);
      cfg_r.nominal <= OHMS_W'(8600);
      cfg_r.divider <= OHMS_W'(10000);
      cfg_r.supply  <= SUPPLY_W'(5000);
      cfg_r.vref    <= REF_W'(3300);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BETA:    cfg_r.beta    <= cfg_wdata[BETA_W-1:0];
        REG_NOMINAL: cfg_r.nominal <= cfg_wdata[OHMS_W-1:0];
        REG_DIVIDER: cfg_r.divider <= cfg_wdata[OHMS_W-1:0];
        REG_SUPPLY:  cfg_r.supply  <= cfg_wdata[SUPPLY_W-1:0];
        REG_REF:     cfg_r.vref    <= cfg_wdata[REF_W-1:0];
        default: ;
      endcase
    end
  end

  thbt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_abort   (in_abort),
    .queue_full (queue_full),
    .push       (push)
  );

  thbt_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (queue_full),
    .pop   (pop),
    .head  (head)
  );

  thbt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_temp_centi (out_temp_centi),
    .out_fault      (out_fault)
  );

endmodule

// ===== rtl/core/thbt_checker.sv =====
module thbt_checker
  import thbt_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [TEMP_W-1:0] out_temp_centi,
  input logic                     out_fault
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temp_centi) && $stable(out_fault))
    else $error("stalled result word changed");

  // A fault always reports absolute zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_temp_centi == -TEMP_W'(ZERO_K_CENTI))
    else $error("fault word with wrong temperature");

  // Temperatures stay within the output range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_centi <= $signed(TEMP_W'(TEMP_MAX)) &&
                  out_temp_centi >= -$signed(TEMP_W'(ZERO_K_CENTI)))
    else $error("temperature out of range");

  // A result needs a batch, so none follows reset at once.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind thermistor_beta_temperature_core thbt_checker u_thbt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_temp_centi (out_temp_centi),
  .out_fault      (out_fault)
);
